// File: design/abf_pkg.sv
// Shared types and constants for the ADC border finder.
// No dependencies; abf_if, abf_front, abf_back and the top level use this package.
package abf_pkg;

    localparam int DEF_INDEX_BITS  = 20;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int QUEUE_DEPTH     = 4;

    localparam int FCNT_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FENCE_WIDTH_RESET     = 8;
    localparam int UNDER_THRESHOLD_RESET = 0;
    localparam int OVER_THRESHOLD_RESET  = 4095;
    localparam int UNDER_LIMIT_RESET     = 0;
    localparam int OVER_LIMIT_RESET      = 4095;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FENCE_WIDTH     = 3'd0,
        CFG_UNDER_THRESHOLD = 3'd1,
        CFG_OVER_THRESHOLD  = 3'd2,
        CFG_UNDER_LIMIT     = 3'd3,
        CFG_OVER_LIMIT      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_UNDER_BORDER = 3'd0,
        KIND_OVER_BORDER  = 3'd1,
        KIND_UNDER_ERROR  = 3'd2,
        KIND_OVER_ERROR   = 3'd3,
        KIND_DONE         = 3'd4
    } t_kind;

    typedef struct packed {
        logic  ev;
        t_kind kind;
        logic  done;
    } t_pkt_ctl;

endpackage

// File: design/abf_if.sv
// Handshake interfaces of the ADC border finder: sample, result and config channels.
// Depends on abf_pkg for the result kind and config field widths.
interface abf_sample_if #(
    parameter int SAMPLE_BITS = abf_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_code;
    logic                   first_of_record;
    logic                   last_of_record;

    modport source (output valid, output sample_code, output first_of_record,
                    output last_of_record, input ready);
    modport sink (input valid, input sample_code, input first_of_record,
                  input last_of_record, output ready);
endinterface

interface abf_result_if #(
    parameter int INDEX_BITS = abf_pkg::DEF_INDEX_BITS
);
    logic                  valid;
    logic                  ready;
    abf_pkg::t_kind        result_kind;
    logic [INDEX_BITS-1:0] border_start;
    logic [INDEX_BITS:0]   border_end;
    logic [INDEX_BITS-1:0] error_index;
    logic                  last_result;

    modport source (output valid, output result_kind, output border_start,
                    output border_end, output error_index, output last_result,
                    input ready);
    modport sink (input valid, input result_kind, input border_start,
                  input border_end, input error_index, input last_result,
                  output ready);
endinterface

interface abf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [abf_pkg::CFG_IDX_W-1:0]    index;
    logic [abf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/abf_front.sv
// Front end: config registers, sample classification and border search state.
// Depends on abf_pkg and abf_if; pushes one packet per sample that yields results.
module abf_front #(
    parameter int INDEX_BITS  = abf_pkg::DEF_INDEX_BITS,
    parameter int SAMPLE_BITS = abf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    abf_sample_if.sink            i_sample,
    abf_cfg_if.sink               i_cfg,
    input  logic                  i_full,
    output logic                  o_push,
    output abf_pkg::t_pkt_ctl     o_ctl,
    output logic [INDEX_BITS-1:0] o_bs,
    output logic [INDEX_BITS:0]   o_be,
    output logic [INDEX_BITS-1:0] o_idx
);
    import abf_pkg::*;

    typedef enum logic [4:0] {
        MODE_UNKNOWN = 5'b00001,
        MODE_UNDER   = 5'b00010,
        MODE_RISING  = 5'b00100,
        MODE_OVER    = 5'b01000,
        MODE_FALLING = 5'b10000
    } t_mode;

    logic [FCNT_W-1:0]      r_fence_width;
    logic [SAMPLE_BITS-1:0] r_under_th;
    logic [SAMPLE_BITS-1:0] r_over_th;
    logic [SAMPLE_BITS-1:0] r_under_lim;
    logic [SAMPLE_BITS-1:0] r_over_lim;

    logic                  r_start, n_start;
    t_mode                 r_mode, n_mode;
    logic [FCNT_W-1:0]     r_fcnt, n_fcnt;
    logic [INDEX_BITS-1:0] r_idx, n_idx;
    logic [INDEX_BITS-1:0] r_bs, n_bs;
    logic [INDEX_BITS:0]   r_be, n_be;
    logic                  r_halt, n_halt;

    logic                  cur_start, cur_halt;
    t_mode                 cur_mode;
    logic [FCNT_W-1:0]     cur_fcnt, fcnt_inc;
    logic [INDEX_BITS-1:0] cur_idx, cur_bs;
    logic [INDEX_BITS:0]   cur_be, idx_plus;
    logic                  accept, first;
    logic                  is_under, is_over, is_fence, in_under, in_over, crossed;
    logic                  ev;
    t_kind                 ev_kind;
    logic [SAMPLE_BITS-1:0] code;

    assign accept        = i_sample.valid && i_sample.ready;
    assign i_sample.ready = !i_full;
    assign i_cfg.ready   = 1'b1;
    assign first         = i_sample.first_of_record;
    assign code          = i_sample.sample_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fence_width <= FCNT_W'(FENCE_WIDTH_RESET);
            r_under_th    <= SAMPLE_BITS'(UNDER_THRESHOLD_RESET);
            r_over_th     <= SAMPLE_BITS'(OVER_THRESHOLD_RESET);
            r_under_lim   <= SAMPLE_BITS'(UNDER_LIMIT_RESET);
            r_over_lim    <= SAMPLE_BITS'(OVER_LIMIT_RESET);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FENCE_WIDTH:     r_fence_width <= i_cfg.data[FCNT_W-1:0];
                CFG_UNDER_THRESHOLD: r_under_th    <= i_cfg.data[SAMPLE_BITS-1:0];
                CFG_OVER_THRESHOLD:  r_over_th     <= i_cfg.data[SAMPLE_BITS-1:0];
                CFG_UNDER_LIMIT:     r_under_lim   <= i_cfg.data[SAMPLE_BITS-1:0];
                CFG_OVER_LIMIT:      r_over_lim    <= i_cfg.data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_start = first ? 1'b0 : r_start;
        cur_mode  = first ? MODE_UNKNOWN : r_mode;
        cur_fcnt  = first ? '0 : r_fcnt;
        cur_idx   = first ? '0 : r_idx;
        cur_bs    = first ? '0 : r_bs;
        cur_be    = first ? '0 : r_be;
        cur_halt  = first ? 1'b0 : r_halt;

        is_under = code <= r_under_th;
        is_over  = code >= r_over_th;
        is_fence = !is_under && !is_over;
        in_under = cur_mode == MODE_UNDER;
        in_over  = cur_mode == MODE_OVER;
        crossed  = (in_under && code > r_under_lim) || (in_over && code < r_over_lim);
        fcnt_inc = (&cur_fcnt) ? cur_fcnt : cur_fcnt + 1'b1;
        idx_plus = {1'b0, cur_idx} + 1'b1;

        n_start = cur_start;
        n_mode  = cur_mode;
        n_fcnt  = cur_fcnt;
        n_bs    = cur_bs;
        n_be    = cur_be;
        n_halt  = cur_halt;
        n_idx   = (&cur_idx) ? cur_idx : cur_idx + 1'b1;
        ev      = 1'b0;
        ev_kind = KIND_UNDER_BORDER;

        if (!cur_halt) begin
            if (!cur_start) begin
                if (is_fence) begin
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= r_fence_width) begin
                        n_start = 1'b1;
                    end
                end else begin
                    n_fcnt = '0;
                end
            end else if (in_under || in_over) begin
                if (is_fence) begin
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= r_fence_width || crossed) begin
                        ev      = 1'b1;
                        ev_kind = in_under ? KIND_UNDER_BORDER : KIND_OVER_BORDER;
                        n_bs    = '0;
                        n_be    = '0;
                        n_mode  = in_under ? MODE_RISING : MODE_FALLING;
                    end
                end else if (crossed) begin
                    ev      = 1'b1;
                    ev_kind = in_under ? KIND_UNDER_ERROR : KIND_OVER_ERROR;
                    n_halt  = 1'b1;
                end else begin
                    n_fcnt = '0;
                    n_be   = idx_plus;
                end
            end else begin
                if (is_under || is_over) begin
                    if (cur_fcnt < r_fence_width) begin
                        n_fcnt = fcnt_inc;
                    end else begin
                        n_bs   = cur_idx;
                        n_be   = idx_plus;
                        n_mode = is_under ? MODE_UNDER : MODE_OVER;
                        n_fcnt = '0;
                    end
                end else begin
                    n_fcnt = fcnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
            r_mode  <= MODE_UNKNOWN;
            r_fcnt  <= '0;
            r_idx   <= '0;
            r_bs    <= '0;
            r_be    <= '0;
            r_halt  <= 1'b0;
        end else if (accept) begin
            r_start <= n_start;
            r_mode  <= n_mode;
            r_fcnt  <= n_fcnt;
            r_idx   <= n_idx;
            r_bs    <= n_bs;
            r_be    <= n_be;
            r_halt  <= n_halt;
        end
    end

    assign o_push     = accept && (ev || i_sample.last_of_record);
    assign o_ctl.ev   = ev;
    assign o_ctl.kind = ev_kind;
    assign o_ctl.done = i_sample.last_of_record;
    assign o_bs       = cur_bs;
    assign o_be       = cur_be;
    assign o_idx      = cur_idx;

    a_mode_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_UNKNOWN |-> r_start)
        else $error("border mode without start fence");
    a_halt_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> r_start && (r_mode == MODE_UNDER || r_mode == MODE_OVER))
        else $error("halted outside a border");
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt && !(accept && first) |=> r_halt)
        else $error("halt dropped without record start");
    a_open_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_UNDER || r_mode == MODE_OVER) |-> r_be > {1'b0, r_bs})
        else $error("open border end not past its start");

endmodule

// File: design/abf_fifo.sv
// Short packet queue between the front end and the result back end.
// Generic width and depth; no package dependency beyond the defaults in the top level.
module abf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// File: design/abf_back.sv
// Back end: pops result packets and issues their one or two results in order.
// Depends on abf_pkg and abf_if; holds one packet and one registered output transaction.
module abf_back #(
    parameter int INDEX_BITS = abf_pkg::DEF_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  abf_pkg::t_pkt_ctl     i_ctl,
    input  logic [INDEX_BITS-1:0] i_bs,
    input  logic [INDEX_BITS:0]   i_be,
    input  logic [INDEX_BITS-1:0] i_idx,
    output logic                  o_pop,
    abf_result_if.source          o_result
);
    import abf_pkg::*;

    logic                  r_hold_ev, r_hold_done;
    t_kind                 r_hold_kind;
    logic [INDEX_BITS-1:0] r_hold_bs, r_hold_idx;
    logic [INDEX_BITS:0]   r_hold_be;

    logic                  r_out_valid;
    t_kind                 r_out_kind, n_out_kind;
    logic [INDEX_BITS-1:0] r_out_bs, n_out_bs;
    logic [INDEX_BITS:0]   r_out_be, n_out_be;
    logic [INDEX_BITS-1:0] r_out_ei, n_out_ei;
    logic                  r_out_last, n_out_last;

    logic load, hold_any, emit, hold_clear;

    assign load       = !r_out_valid || o_result.ready;
    assign hold_any   = r_hold_ev || r_hold_done;
    assign emit       = load && hold_any;
    assign hold_clear = !hold_any || (emit && !(r_hold_ev && r_hold_done));
    assign o_pop      = i_valid && hold_clear;

    always_comb begin
        if (r_hold_ev) begin
            n_out_kind = r_hold_kind;
            n_out_bs   = r_hold_bs;
            n_out_be   = r_hold_be;
            n_out_ei   = (r_hold_kind == KIND_UNDER_ERROR || r_hold_kind == KIND_OVER_ERROR)
                         ? r_hold_idx : '0;
            n_out_last = !r_hold_done;
        end else begin
            n_out_kind = KIND_DONE;
            n_out_bs   = '0;
            n_out_be   = '0;
            n_out_ei   = r_hold_idx;
            n_out_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hold_ev   <= 1'b0;
            r_hold_done <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= hold_any;
            end
            if (o_pop) begin
                r_hold_ev   <= i_ctl.ev;
                r_hold_done <= i_ctl.done;
            end else if (emit) begin
                if (r_hold_ev) begin
                    r_hold_ev <= 1'b0;
                end else begin
                    r_hold_done <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hold_kind <= i_ctl.kind;
            r_hold_bs   <= i_bs;
            r_hold_be   <= i_be;
            r_hold_idx  <= i_idx;
        end
        if (emit) begin
            r_out_kind <= n_out_kind;
            r_out_bs   <= n_out_bs;
            r_out_be   <= n_out_be;
            r_out_ei   <= n_out_ei;
            r_out_last <= n_out_last;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.result_kind  = r_out_kind;
    assign o_result.border_start = r_out_bs;
    assign o_result.border_end   = r_out_be;
    assign o_result.error_index  = r_out_ei;
    assign o_result.last_result  = r_out_last;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_DONE |-> r_out_last && r_out_bs == '0 && r_out_be == '0)
        else $error("done result malformed");
    a_border_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind == KIND_UNDER_BORDER || r_out_kind == KIND_OVER_BORDER)
        |-> r_out_ei == '0)
        else $error("border result carries an index");
    a_error_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_hold_done && !r_hold_ev)
        else $error("first of two results lost its follower");

endmodule

// File: design/adc_border_finder.sv
// Top level of the ADC border finder: front end, packet queue and result back end.
// Depends on abf_pkg, abf_if, abf_front, abf_fifo and abf_back.
//
//  channel    dir  transaction                                   payload
//  i_sample   in   one ADC sample with record marks              code, first, last
//  i_cfg      in   one register write, index 0..4                index, data
//  o_result   out  border, error or done, one per transaction    kind, start, end, index, last
//
//  A sample is taken every cycle while the packet queue has room; the search state updates
//  in that same cycle, and its results pass the queue and the back end's hold and output
//  registers. Each packet drains at one result per cycle while o_result is ready: a sample
//  with two results makes two transactions. Reset is synchronous and clears all search state
//  and loads the register defaults; o_result stalls back up through the queue to i_sample.
module adc_border_finder #(
    parameter int INDEX_BITS  = abf_pkg::DEF_INDEX_BITS,
    parameter int SAMPLE_BITS = abf_pkg::DEF_SAMPLE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    abf_sample_if.sink    i_sample,
    abf_cfg_if.sink       i_cfg,
    abf_result_if.source  o_result
);
    import abf_pkg::*;

    localparam int PKT_W = $bits(t_pkt_ctl) + 3 * INDEX_BITS + 1;

    logic                  push, pop, full, q_valid;
    t_pkt_ctl              f_ctl, b_ctl;
    logic [INDEX_BITS-1:0] f_bs, f_idx, b_bs, b_idx;
    logic [INDEX_BITS:0]   f_be, b_be;
    logic [PKT_W-1:0]      q_in, q_out;

    abf_front #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (i_cfg),
        .i_full   (full),
        .o_push   (push),
        .o_ctl    (f_ctl),
        .o_bs     (f_bs),
        .o_be     (f_be),
        .o_idx    (f_idx)
    );

    assign q_in = {f_ctl, f_bs, f_be, f_idx};

    abf_fifo #(
        .WIDTH (PKT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_ctl, b_bs, b_be, b_idx} = q_out;

    abf_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_ctl    (b_ctl),
        .i_bs     (b_bs),
        .i_be     (b_be),
        .i_idx    (b_idx),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
